### hw/rtl/sir90_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sir90_pkg
// Shared constants and controller/datapath interface types for the square
// frame rotator.
// ----------------------------------------------------------------------------
package sir90_pkg;

  localparam int unsigned MaxSideDef   = 64;
  localparam int unsigned PixelBitsDef = 32;

  localparam int unsigned PixW      = 32;
  localparam int unsigned SizeW     = 7;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 7;

  localparam logic [SizeW-1:0] SizeReset = 7'd64;

  localparam logic [CfgIdxW-1:0] CFG_IDX_SIZE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_DIR  = 2'd1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_ACW = 1'b1;

  typedef struct packed {
    logic load;     // store incoming pixel, step load position
    logic rd_issue; // start store read of next rotated pixel
    logic rd_blank; // answer a read with an empty word
    logic capture;  // move store read data to output register
  } cmd_t;

  typedef struct packed {
    logic frame_ready;
    logic out_valid;
  } sts_t;

endpackage

### hw/rtl/sir90_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sir90_ctrl
// Controller: input handshake and read sequencing for the frame rotator.
// ----------------------------------------------------------------------------
module sir90_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            kind_i,
  input  logic            out_ready_i,
  input  sir90_pkg::sts_t sts_i,
  output sir90_pkg::cmd_t cmd_o
);
  import sir90_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_ready_o = (state_q == ST_IDLE) && (!sts_i.out_valid || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.load     = accept && (kind_i == KIND_WRITE) && !sts_i.frame_ready;
    cmd_o.rd_issue = accept && (kind_i == KIND_READ) && sts_i.frame_ready;
    cmd_o.rd_blank = accept && (kind_i == KIND_READ) && !sts_i.frame_ready;
    cmd_o.capture  = (state_q == ST_READ);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.rd_issue) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_issue_then_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_issue |=> (state_q == ST_READ))
    else $error("read issue not followed by read state");

  a_read_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |=> (state_q == ST_IDLE))
    else $error("read state held more than one cycle");

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.rd_issue, cmd_o.rd_blank, cmd_o.capture}))
    else $error("datapath commands overlap");

endmodule

### hw/rtl/sir90_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sir90_dp
// Datapath: config registers, load and readout counters, rotated address
// generation, frame store and output register.
// ----------------------------------------------------------------------------
module sir90_dp #(
  parameter int unsigned MAX_SIDE   = sir90_pkg::MaxSideDef,
  parameter int unsigned PIXEL_BITS = sir90_pkg::PixelBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sir90_pkg::cmd_t                     cmd_i,
  output sir90_pkg::sts_t                     sts_o,
  input  logic signed [sir90_pkg::PixW-1:0]   pixel_in_i,
  input  logic                                cfg_valid_i,
  input  logic [sir90_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sir90_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [sir90_pkg::PixW-1:0]   pixel_out_o,
  output logic                                row_end_o,
  output logic                                frame_end_o,
  output logic                                valid_res_o
);
  import sir90_pkg::*;

  localparam int unsigned CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned NW    = $clog2(MAX_SIDE + 1);
  localparam int unsigned FW    = (NW > SizeW) ? NW : SizeW;
  localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [SizeW-1:0] size_q;
  logic             dir_q;
  logic [FW-1:0]    size_ext, side;
  logic [CW-1:0]    last_idx;
  logic             restart;

  logic [CW-1:0] load_row_q, load_row_d, load_col_q, load_col_d;
  logic [CW-1:0] out_row_q, out_row_d, out_col_q, out_col_d;
  logic          frame_ready_q, frame_ready_d;

  logic          re, fe;
  logic [CW-1:0] src_r, src_c;
  logic [AW-1:0] wr_addr, rd_addr;

  logic [PIXEL_BITS-1:0]        mem_q [DEPTH];
  logic signed [PIXEL_BITS-1:0] rd_data_q;
  logic                         pend_re_q, pend_fe_q;

  logic                out_valid_q;
  logic signed [PixW-1:0] out_pixel_q;
  logic                out_re_q, out_fe_q, out_vres_q;

  // config registers
  assign restart = cfg_valid_i && ((cfg_index_i == CFG_IDX_SIZE) ||
                                   (cfg_index_i == CFG_IDX_DIR));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
      dir_q  <= DIR_CW;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_IDX_SIZE) begin
        size_q <= cfg_data_i[SizeW-1:0];
      end else if (cfg_index_i == CFG_IDX_DIR) begin
        dir_q <= cfg_data_i[0];
      end
    end
  end

  // side length clamped to 1..MAX_SIDE
  always_comb begin
    size_ext = FW'(size_q);
    if (size_ext == '0) begin
      side = FW'(1);
    end else if (size_ext > FW'(MAX_SIDE)) begin
      side = FW'(MAX_SIDE);
    end else begin
      side = size_ext;
    end
    last_idx = CW'(side - FW'(1));
  end

  // load and readout positions, frame ready flag
  always_comb begin
    load_row_d    = load_row_q;
    load_col_d    = load_col_q;
    frame_ready_d = frame_ready_q;
    out_row_d     = out_row_q;
    out_col_d     = out_col_q;
    re            = (out_col_q == last_idx);
    fe            = re && (out_row_q == last_idx);
    if (restart) begin
      load_row_d    = '0;
      load_col_d    = '0;
      out_row_d     = '0;
      out_col_d     = '0;
      frame_ready_d = 1'b0;
    end else if (cmd_i.load) begin
      if (load_col_q == last_idx) begin
        load_col_d = '0;
        if (load_row_q == last_idx) begin
          load_row_d    = '0;
          frame_ready_d = 1'b1;
        end else begin
          load_row_d = load_row_q + CW'(1);
        end
      end else begin
        load_col_d = load_col_q + CW'(1);
      end
    end else if (cmd_i.rd_issue) begin
      if (fe) begin
        out_row_d     = '0;
        out_col_d     = '0;
        frame_ready_d = 1'b0;
      end else if (re) begin
        out_col_d = '0;
        out_row_d = out_row_q + CW'(1);
      end else begin
        out_col_d = out_col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_row_q    <= '0;
      load_col_q    <= '0;
      out_row_q     <= '0;
      out_col_q     <= '0;
      frame_ready_q <= 1'b0;
    end else begin
      load_row_q    <= load_row_d;
      load_col_q    <= load_col_d;
      out_row_q     <= out_row_d;
      out_col_q     <= out_col_d;
      frame_ready_q <= frame_ready_d;
    end
  end

  // rotated source position and store addresses
  always_comb begin
    if (dir_q == DIR_CW) begin
      src_r = last_idx - out_col_q;
      src_c = out_row_q;
    end else begin
      src_r = out_col_q;
      src_c = last_idx - out_row_q;
    end
    wr_addr = AW'(load_row_q) * AW'(MAX_SIDE) + AW'(load_col_q);
    rd_addr = AW'(src_r) * AW'(MAX_SIDE) + AW'(src_c);
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem_q[wr_addr] <= PIXEL_BITS'(pixel_in_i);
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem_q[rd_addr];
      pend_re_q <= re;
      pend_fe_q <= fe;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.capture || cmd_i.rd_blank) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      out_pixel_q <= PixW'(rd_data_q);
      out_re_q    <= pend_re_q;
      out_fe_q    <= pend_fe_q;
      out_vres_q  <= 1'b1;
    end else if (cmd_i.rd_blank) begin
      out_pixel_q <= '0;
      out_re_q    <= 1'b0;
      out_fe_q    <= 1'b0;
      out_vres_q  <= 1'b0;
    end
  end

  assign sts_o.frame_ready = frame_ready_q;
  assign sts_o.out_valid   = out_valid_q;
  assign out_valid_o       = out_valid_q;
  assign pixel_out_o       = out_pixel_q;
  assign row_end_o         = out_re_q;
  assign frame_end_o       = out_fe_q;
  assign valid_res_o       = out_vres_q;

  a_issue_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_issue |-> frame_ready_q)
    else $error("store read without a full frame");

  a_ready_load_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_ready_q |-> (load_row_q == '0) && (load_col_q == '0))
    else $error("load position not home while frame ready");

  a_counters_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_row_q <= last_idx) && (load_col_q <= last_idx) &&
    (out_row_q <= last_idx) && (out_col_q <= last_idx))
    else $error("position outside frame");

endmodule

### hw/rtl/square_image_rotate_90_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_image_rotate_90_core
// Rotates a square frame by 90 degrees, clockwise or anticlockwise.
//
// Input channel (in_valid_i/in_ready_o): kind_i 0 loads the next pixel of
// the frame in row-major order; kind_i 1 reads the next pixel of the rotated
// frame. A load word produces no result and is taken one per cycle while no
// store read is under way and the output is not stalled; a load while a full
// frame waits is dropped. A read before the frame is complete returns a word
// with valid_res_o low in the cycle after acceptance. A read of the stored
// frame passes the registered store read port, then the output register, and
// no new input is taken meanwhile. Output channel (out_valid_o/out_ready_i)
// is a single output register: a stalled receiver holds it, and new input is
// taken only once it is free or being taken in the same cycle.
// Config channel (cfg_valid_i/cfg_ready_o, always ready): index 0 frame
// side length, index 1 rotation sense; either write restarts loading.
// Reset: side 64, clockwise, loading phase; store contents left undefined,
// no clearing pass.
// ----------------------------------------------------------------------------
module square_image_rotate_90_core #(
  parameter int unsigned MAX_SIDE   = sir90_pkg::MaxSideDef,
  parameter int unsigned PIXEL_BITS = sir90_pkg::PixelBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              kind_i,
  input  logic signed [sir90_pkg::PixW-1:0] pixel_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [sir90_pkg::PixW-1:0] pixel_out_o,
  output logic                              row_end_o,
  output logic                              frame_end_o,
  output logic                              valid_res_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sir90_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [sir90_pkg::CfgDataW-1:0]    cfg_data_i
);
  import sir90_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  sir90_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sir90_dp #(
    .MAX_SIDE   (MAX_SIDE),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .pixel_in_i  (pixel_in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .pixel_out_o (pixel_out_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o),
    .valid_res_o (valid_res_o)
  );

endmodule
